>>> src/rdn_pkg.sv
// Shared types and constants of the relative difference norm unit.
package rdn_pkg;

  localparam int unsigned RDN_QUEUE_DEPTH = 2;
  localparam logic [63:0] ONE_Q12         = 64'd4096;
  localparam logic [47:0] OUT_MAX         = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_INF  = 2'd0,
    KIND_L1   = 2'd1,
    KIND_L2   = 2'd2,
    KIND_NONE = 2'd3
  } norm_kind_t;

  typedef struct packed {
    logic signed [23:0] a_value;
    logic signed [23:0] b_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [47:0] norm_value;
    logic        was_relative;
    logic        saturated;
  } out_item_t;

  // One finished vector on its way from the accumulators to the finisher.
  typedef struct packed {
    logic [63:0] diff_acc;
    logic [63:0] ref_acc;
    logic        overflow;
    norm_kind_t  kind;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROOT_D,
    B_ROOT_R,
    B_CHECK,
    B_DIV,
    B_HOLD
  } back_state_t;

endpackage

>>> src/relative_difference_norm_unit.sv
// Top level of the relative difference norm unit.
//
// Usage:
//   Write cfg_wdata with cfg_we high to pick the norm (0 infinity, 1 L1,
//   2 L2, 3 gives a zero result); write only between vectors.
//   Stream element pairs on the in_ channel (valid/ready). The pair with
//   last set closes a vector and produces exactly one item on the out_
//   channel; other pairs produce nothing.
// Throughput: the front end takes one pair per cycle. It stalls only when
//   a closing pair arrives while the queue already holds QUEUE_DEPTH
//   finished vectors.
// Path per vector, from the accepted last pair to out_valid: the front-end
//   stage register, the queue, the check state, the bit-serial divider when
//   the reference norm is above one, the hold state and the output register;
//   L2 first takes two square roots, one after the other on a single root
//   unit.
//   The back end finishes one vector at a time, so its time per vector also
//   bounds how often vectors can close without filling the queue.
// Reset (rst_n low, synchronous): clears accumulators, queue, back-end
//   state and the output valid; the norm kind returns to infinity.
// Stall: a result waits in the output register while out_ready is low;
//   the back end holds its next result and the queue absorbs more vectors.
module relative_difference_norm_unit import rdn_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = RDN_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  // Front to queue.
  logic job_in_valid;
  logic job_in_ready;
  job_t job_in;

  // Queue to back.
  logic job_out_valid;
  logic job_out_pop;
  job_t job_out;

  // Accumulate magnitudes, maxima or squares per pair.
  rdn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_in_valid),
    .job_ready (job_in_ready),
    .job       (job_in)
  );

  // Hold closed vectors until the back end is free.
  rdn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_in_valid),
    .push_ready (job_in_ready),
    .push_data  (job_in),
    .pop_valid  (job_out_valid),
    .pop_ready  (job_out_pop),
    .pop_data   (job_out)
  );

  // Take roots, divide and drive the result register.
  rdn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_out_valid),
    .job_pop   (job_out_pop),
    .job       (job_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> src/rdn_front.sv
// Front end: accepts element pairs, forms magnitudes or squares and accumulates them or keeps their maxima.
module rdn_front import rdn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  norm_kind_t kind_r;

  logic        s1_valid_r;
  logic        s1_last_r;
  norm_kind_t  s1_kind_r;
  logic [47:0] s1_vd_r;
  logic [47:0] s1_vr_r;

  logic [63:0] acc_d_r, acc_d_nxt;
  logic [63:0] acc_r_r, acc_r_nxt;
  logic        ovf_r, ovf_nxt;

  logic signed [24:0] diff;
  logic signed [24:0] a_ext;
  logic [23:0]        dm;
  logic [23:0]        am;
  logic [47:0]        dsq;
  logic [47:0]        asq;
  logic               advance;
  logic [64:0]        sum_d;
  logic [64:0]        sum_r;

  assign a_ext = {in_item.a_value[23], in_item.a_value};
  assign diff  = a_ext - {in_item.b_value[23], in_item.b_value};
  assign dm    = diff[24] ? 24'(-diff) : diff[23:0];
  assign am    = a_ext[24] ? 24'(-a_ext) : a_ext[23:0];
  assign dsq   = {24'd0, dm} * {24'd0, dm};
  assign asq   = {24'd0, am} * {24'd0, am};

  assign advance  = s1_valid_r && (!s1_last_r || job_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_INF;
    end else if (cfg_we) begin
      kind_r <= norm_kind_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_last_r <= in_item.last;
      s1_kind_r <= kind_r;
      s1_vd_r   <= (kind_r == KIND_L2) ? dsq : {24'd0, dm};
      s1_vr_r   <= (kind_r == KIND_L2) ? asq : {24'd0, am};
    end
  end

  assign sum_d = {1'b0, acc_d_r} + {17'd0, s1_vd_r};
  assign sum_r = {1'b0, acc_r_r} + {17'd0, s1_vr_r};

  always_comb begin
    acc_d_nxt = acc_d_r;
    acc_r_nxt = acc_r_r;
    ovf_nxt   = ovf_r;
    case (s1_kind_r)
      KIND_INF: begin
        if ({16'd0, s1_vd_r} > acc_d_r) acc_d_nxt = {16'd0, s1_vd_r};
        if ({16'd0, s1_vr_r} > acc_r_r) acc_r_nxt = {16'd0, s1_vr_r};
      end
      KIND_L1, KIND_L2: begin
        acc_d_nxt = sum_d[64] ? {64{1'b1}} : sum_d[63:0];
        acc_r_nxt = sum_r[64] ? {64{1'b1}} : sum_r[63:0];
        ovf_nxt   = ovf_r | sum_d[64] | sum_r[64];
      end
      default: begin
      end
    endcase
  end

  assign job_valid     = s1_valid_r && s1_last_r;
  assign job.diff_acc  = acc_d_nxt;
  assign job.ref_acc   = acc_r_nxt;
  assign job.overflow  = ovf_nxt;
  assign job.kind      = s1_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_d_r <= '0;
      acc_r_r <= '0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      // Clear on the last element so the next vector starts from zero.
      acc_d_r <= s1_last_r ? '0 : acc_d_nxt;
      acc_r_r <= s1_last_r ? '0 : acc_r_nxt;
      ovf_r   <= s1_last_r ? 1'b0 : ovf_nxt;
    end
  end

endmodule

>>> src/rdn_fifo.sv
// Short queue of finished accumulator pairs between front and back.
module rdn_fifo import rdn_pkg::*; #(
  parameter int unsigned DEPTH = RDN_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> src/rdn_isqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
module rdn_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);

  localparam int unsigned STEPS = 32;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      x_r;
  logic [33:0]      rem_r;
  logic [31:0]      root_r;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  assign rem_sh = {rem_r, x_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[61:0], 2'b00};
      rem_r  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_r <= {root_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> src/rdn_div.sv
// Restoring divider: floor(num * 4096 / den), one quotient bit per cycle, saturated to 48 bits.
module rdn_div import rdn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [47:0] quotient,
  output logic        overflow
);

  localparam int unsigned STEPS = 76;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [75:0]      dvd_r;
  logic [75:0]      q_r;
  logic [63:0]      rem_r;
  logic [63:0]      den_r;

  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r, dvd_r[75]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, 12'd0};
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[74:0], 1'b0};
      rem_r <= fits ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
      q_r   <= {q_r[74:0], fits};
    end
  end

  assign done     = done_r;
  assign overflow = |q_r[75:48];
  assign quotient = overflow ? OUT_MAX : q_r[47:0];

endmodule

>>> src/rdn_back.sv
// Back end: takes roots for L2, divides by the reference norm when it is above one and holds the result.
module rdn_back import rdn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_pop,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;
  logic [63:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt;
  logic        ovf_r, ovf_nxt;
  logic [47:0] res_r, res_nxt;
  logic        rel_r, rel_nxt;
  logic        sat_r, sat_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        sq_start;
  logic [63:0] sq_operand;
  logic        sq_done;
  logic [31:0] sq_root;
  logic        dv_start;
  logic        dv_done;
  logic [47:0] dv_q;
  logic        dv_ovf;

  rdn_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  rdn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .num      (num_r),
    .den      (den_r),
    .done     (dv_done),
    .quotient (dv_q),
    .overflow (dv_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    ovf_r      <= ovf_nxt;
    res_r      <= res_nxt;
    rel_r      <= rel_nxt;
    sat_r      <= sat_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    rel_nxt       = rel_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    job_pop       = 1'b0;
    sq_start      = 1'b0;
    sq_operand    = job.diff_acc;
    dv_start      = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          num_nxt = job.diff_acc;
          den_nxt = job.ref_acc;
          ovf_nxt = job.overflow;
          if (job.kind == KIND_L2) begin
            sq_start  = 1'b1;
            state_nxt = B_ROOT_D;
          end else begin
            state_nxt = B_CHECK;
          end
        end
      end
      B_ROOT_D: begin
        sq_operand = den_r;
        if (sq_done) begin
          num_nxt   = {32'd0, sq_root};
          sq_start  = 1'b1;
          state_nxt = B_ROOT_R;
        end
      end
      B_ROOT_R: begin
        if (sq_done) begin
          den_nxt   = {32'd0, sq_root};
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (den_r > ONE_Q12) begin
          dv_start  = 1'b1;
          state_nxt = B_DIV;
        end else begin
          res_nxt   = (|num_r[63:48]) ? OUT_MAX : num_r[47:0];
          sat_nxt   = ovf_r | (|num_r[63:48]);
          rel_nxt   = 1'b0;
          state_nxt = B_HOLD;
        end
      end
      B_DIV: begin
        if (dv_done) begin
          res_nxt   = dv_q;
          sat_nxt   = ovf_r | dv_ovf;
          rel_nxt   = 1'b1;
          state_nxt = B_HOLD;
        end
      end
      B_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.norm_value   = res_r;
          out_item_nxt.was_relative = rel_r;
          out_item_nxt.saturated    = sat_r;
          state_nxt                 = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_root_in_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == B_ROOT_D || state_r == B_ROOT_R))
    else $error("square root finished outside a root state");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> state_r == B_DIV)
    else $error("divider finished outside the divide state");

  a_relative_needs_big_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_HOLD && rel_r) |-> den_r > ONE_Q12)
    else $error("relative result with reference norm not above one");

endmodule
